@@ rtl/arst_pkg.sv @@
package arst_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int ADDR_BITS_DEF = 48;
  localparam int HANDLE_BITS   = 32;
  localparam int LEN_BITS      = 31;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // control part of the token that walks down the cell chain
  typedef struct packed {
    logic       valid;
    logic [1:0] action;
    logic       status;
    logic       claimed;
    logic       hit;
  } ctrl_t;

endpackage

@@ rtl/arst_cell.sv @@
module arst_cell #(
  parameter int ADDR_BITS = arst_pkg::ADDR_BITS_DEF,
  parameter int CNT_W     = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  arst_pkg::ctrl_t               ctrl_in,
  input  logic [CNT_W-1:0]              left_in,
  input  logic [ADDR_BITS-1:0]          start_in,
  input  logic [ADDR_BITS:0]            aux_in,
  input  logic [arst_pkg::HANDLE_BITS-1:0] handle_in,
  output arst_pkg::ctrl_t               ctrl_out,
  output logic [CNT_W-1:0]              left_out,
  output logic [ADDR_BITS-1:0]          start_out,
  output logic [ADDR_BITS:0]            aux_out,
  output logic [arst_pkg::HANDLE_BITS-1:0] handle_out
);
  import arst_pkg::*;

  logic [ADDR_BITS-1:0]   ent_start;
  logic [ADDR_BITS:0]     ent_end;
  logic [HANDLE_BITS-1:0] ent_handle;

  logic occupied;
  logic live;
  logic add_here;
  logic rm_match;
  logic fd_match;

  // entry is occupied while the token still has entries left to pass
  assign occupied = (left_in != '0);
  assign live     = ctrl_in.valid && !ctrl_in.claimed;
  assign add_here = live && (ctrl_in.action == ACT_ADD) && !occupied;
  assign rm_match = live && (ctrl_in.action == ACT_REMOVE) && occupied &&
                    (ent_start == start_in) && (ent_handle == handle_in);
  assign fd_match = live && (ctrl_in.action == ACT_FIND) && occupied &&
                    (aux_in[ADDR_BITS-1:0] >= ent_start) &&
                    (ent_end[ADDR_BITS] || (aux_in[ADDR_BITS-1:0] < ent_end[ADDR_BITS-1:0]));

  always_ff @(posedge clk) begin
    if (add_here) begin
      ent_start  <= start_in;
      ent_end    <= aux_in;
      ent_handle <= handle_in;
    end else if (rm_match) begin
      ent_handle <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out.valid   <= ctrl_in.valid;
      ctrl_out.action  <= ctrl_in.action;
      ctrl_out.status  <= ctrl_in.status;
      ctrl_out.claimed <= ctrl_in.claimed | add_here | rm_match | fd_match;
      ctrl_out.hit     <= ctrl_in.hit | rm_match | fd_match;
    end
  end

  always_ff @(posedge clk) begin
    left_out   <= occupied ? (left_in - CNT_W'(1)) : '0;
    start_out  <= start_in;
    aux_out    <= aux_in;
    handle_out <= fd_match ? ent_handle : handle_in;
  end

endmodule

@@ rtl/address_range_symbol_table_top.sv @@
// address range table: up to CAPACITY ranges, each tagged with a 32-bit handle
//
// command channel: an item transfers on a rising edge with start high and busy
// low; action selects add (append range_start .. range_start+range_length),
// remove (zero the handle of the first entry matching range_start and handle)
// or find (handle of the first entry holding query_address)
// result channel: found_handle, hit and status are valid for exactly one cycle
// while done is high; the receiver cannot stall, so every result transfers
// entries live one per cell in a chain; an item walks the chain one cell per
// cycle, so done rises once the item reaches the last cell's output register (the result
// transfers at the edge after that) and the next item can be accepted once
// the sequencer has returned to idle after that result
// the chain length (one register stage per entry) sets the walk time of an item
// an add into a full table is not stored and returns status 1
// reset (synchronous, active high) empties the table and drops any item in
// flight; entry contents are not cleared, only the entry count
module address_range_symbol_table_top #(
  parameter int CAPACITY  = arst_pkg::CAPACITY_DEF,
  parameter int ADDR_BITS = arst_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       action,
  input  logic [ADDR_BITS-1:0]             range_start,
  input  logic [arst_pkg::LEN_BITS-1:0]    range_length,
  input  logic [arst_pkg::HANDLE_BITS-1:0] handle,
  input  logic [ADDR_BITS-1:0]             query_address,
  output logic                             done,
  output logic [arst_pkg::HANDLE_BITS-1:0] found_handle,
  output logic                             hit,
  output logic                             status
);
  import arst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // token chain: index 0 is the injection register, index k+1 is cell k's output
  ctrl_t                  ctrl_c   [CAPACITY+1];
  logic [CNT_W-1:0]       left_c   [CAPACITY+1];
  logic [ADDR_BITS-1:0]   start_c  [CAPACITY+1];
  logic [ADDR_BITS:0]     aux_c    [CAPACITY+1];
  logic [HANDLE_BITS-1:0] handle_c [CAPACITY+1];

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] entry_count;
  logic             accept;
  logic             full;
  logic             is_add;
  logic [ADDR_BITS:0] add_end;
  ctrl_t            ctrl_last;

  assign accept = start && !busy;
  assign full   = (entry_count == CNT_W'(CAPACITY));
  assign is_add = (action == ACT_ADD);

  // end is one bit wider so a range running past the top never wraps
  assign add_end = {1'b0, range_start} +
                   {{(ADDR_BITS + 1 - LEN_BITS){1'b0}}, range_length};

  // sequencer: idle until an item transfers, run until its result leaves the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        busy = 1'b1;
        if (ctrl_last.valid) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // entry count; the chain places an add at the first cell past the count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept && is_add && !full) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // injection register: head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_c[0] <= '0;
    end else begin
      ctrl_c[0].valid   <= accept;
      ctrl_c[0].action  <= action;
      ctrl_c[0].status  <= is_add && full;
      ctrl_c[0].claimed <= 1'b0;
      ctrl_c[0].hit     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_c[0]   <= entry_count;
      start_c[0]  <= range_start;
      aux_c[0]    <= (action == ACT_FIND) ? {1'b0, query_address} : add_end;
      handle_c[0] <= handle;
    end
  end

  // one cell per table entry
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    arst_cell #(
      .ADDR_BITS (ADDR_BITS),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl_in    (ctrl_c[k]),
      .left_in    (left_c[k]),
      .start_in   (start_c[k]),
      .aux_in     (aux_c[k]),
      .handle_in  (handle_c[k]),
      .ctrl_out   (ctrl_c[k+1]),
      .left_out   (left_c[k+1]),
      .start_out  (start_c[k+1]),
      .aux_out    (aux_c[k+1]),
      .handle_out (handle_c[k+1])
    );
  end

  // result comes straight off the last cell's registers
  assign ctrl_last    = ctrl_c[CAPACITY];
  assign done         = ctrl_last.valid;
  assign hit          = ctrl_last.hit;
  assign status       = ctrl_last.status;
  assign found_handle = ((ctrl_last.action == ACT_FIND) && ctrl_last.hit) ?
                        handle_c[CAPACITY] : '0;

  // a result only comes out for an item that is still running
  a_done_busy : assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result without an item in flight");

  // the count never passes the capacity
  a_count_max : assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // a dropped add never reports a match
  a_status_clean : assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (!hit && (found_handle == '0)))
    else $error("dropped add reported a match");

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("block not busy after accepting an item");

endmodule

@@ dv/tb_address_range_symbol_table_top.sv @@
module tb_address_range_symbol_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import arst_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int AW  = ADDR_BITS_DEF;
  localparam int HW  = HANDLE_BITS;
  localparam int LW  = LEN_BITS;

  // action code with no operation behind it: the block must answer all zeros
  localparam logic [1:0] ACT_NONE = 2'd3;

  // settle time: longer than one item's walk down the chain
  localparam int SETTLE_CYCLES = CAP + 8;

  localparam logic [AW-1:0] ADDR_MAX = {AW{1'b1}};

  // one command transfer as the driver presents it
  typedef struct {
    logic [1:0]    action;
    logic [AW-1:0] range_start;
    logic [LW-1:0] range_length;
    logic [HW-1:0] handle;
    logic [AW-1:0] query_address;
    bit            drain;  // hold this one back until every answer is in
  } cmd_t;

  // one answer from the block
  typedef struct {
    logic [HW-1:0] found_handle;
    logic          hit;
    logic          status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // block inputs, known from time zero
  logic          start         = 1'b0;
  logic [1:0]    action        = ACT_ADD;
  logic [AW-1:0] range_start   = '0;
  logic [LW-1:0] range_length  = '0;
  logic [HW-1:0] handle        = '0;
  logic [AW-1:0] query_address = '0;

  logic          busy;
  logic          done;
  logic [HW-1:0] found_handle;
  logic          hit;
  logic          status;

  address_range_symbol_table_top #(
    .CAPACITY (CAP),
    .ADDR_BITS(AW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .range_start  (range_start),
    .range_length (range_length),
    .handle       (handle),
    .query_address(query_address),
    .done         (done),
    .found_handle (found_handle),
    .hit          (hit),
    .status       (status)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // shadow of the range table, updated in transfer order
  // ---------------------------------------------------------------------
  logic [AW-1:0] tbl_start  [CAP];
  logic [AW:0]   tbl_end    [CAP];  // one bit wider, so the end never wraps
  logic [HW-1:0] tbl_handle [CAP];
  int            tbl_count = 0;

  // stats for the closing summary
  int n_added     = 0;
  int n_dropped   = 0;
  int n_find_hit  = 0;
  int n_find_miss = 0;
  int n_rm_hit    = 0;
  int n_rm_miss   = 0;
  int n_none      = 0;
  int n_checked   = 0;
  int n_err       = 0;

  // apply one command to the shadow table and return the answer it must give
  function automatic answer_t table_apply(cmd_t c);
    answer_t a;
    a.found_handle = '0;
    a.hit          = 1'b0;
    a.status       = 1'b0;
    case (c.action)
      ACT_ADD: begin
        if (tbl_count >= CAP) begin
          // full table: nothing stored, flag it
          a.status = 1'b1;
          n_dropped++;
        end else begin
          tbl_start[tbl_count]  = c.range_start;
          tbl_end[tbl_count]    = {1'b0, c.range_start} + (AW+1)'(c.range_length);
          tbl_handle[tbl_count] = c.handle;
          tbl_count++;
          n_added++;
        end
      end
      ACT_REMOVE: begin
        // first entry in insertion order with the same start and handle
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_start[i] == c.range_start && tbl_handle[i] == c.handle) begin
            tbl_handle[i] = '0;
            a.hit = 1'b1;
            break;
          end
        end
        if (a.hit) n_rm_hit++;
        else n_rm_miss++;
      end
      ACT_FIND: begin
        // first entry holding the address; a removed one answers handle 0
        for (int i = 0; i < tbl_count; i++) begin
          if (c.query_address >= tbl_start[i] &&
              {1'b0, c.query_address} < tbl_end[i]) begin
            a.found_handle = tbl_handle[i];
            a.hit = 1'b1;
            break;
          end
        end
        if (a.hit) n_find_hit++;
        else n_find_miss++;
      end
      default: n_none++;
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------
  // command queue, answers still owed, and the mismatch reporter
  // ---------------------------------------------------------------------
  cmd_t    pend_q[$];
  answer_t owed_q[$];
  cmd_t    cur_cmd;
  int      send_idle_pct = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h (answer %0d)",
             $realtime, what, got, want, n_checked);
    n_err++;
  endtask

  // ---------------------------------------------------------------------
  // driver: a transfer happens at an edge with start high and busy low;
  // start stays up while busy, so a new command waits for the chain
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        owed_q.push_back(table_apply(cur_cmd));
      end
      if (!start || !busy) begin
        // free to present the next command, or to idle this cycle
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(pend_q[0].drain && owed_q.size() != 0)) begin
          nxt = pend_q.pop_front();
          cur_cmd = nxt;
          start         <= 1'b1;
          action        <= nxt.action;
          range_start   <= nxt.range_start;
          range_length  <= nxt.range_length;
          handle        <= nxt.handle;
          query_address <= nxt.query_address;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: done marks a one-cycle answer; it cannot be held off, so take
  // it at every edge where done is high and compare with the oldest owed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (owed_q.size() == 0) begin
        report_mismatch("unexpected answer", {32'b0, found_handle}, 64'b0);
      end else begin
        want = owed_q.pop_front();
        if (found_handle !== want.found_handle)
          report_mismatch("found_handle", 64'(found_handle), 64'(want.found_handle));
        if (hit !== want.hit)
          report_mismatch("hit", 64'(hit), 64'(want.hit));
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus side: what the generator has added so far, so that removes
  // and finds can aim at real entries
  // ---------------------------------------------------------------------
  logic [AW-1:0] gen_start  [$];
  logic [LW-1:0] gen_len    [$];
  logic [HW-1:0] gen_handle [$];

  function automatic logic [AW-1:0] rand_addr();
    return AW'({$urandom(), $urandom()});
  endfunction

  // queue one command as given; the random generators fill the fields the action ignores with noise
  task automatic send_cmd(logic [1:0] act, logic [AW-1:0] s, logic [LW-1:0] len,
                          logic [HW-1:0] h, logic [AW-1:0] q, bit drain = 0);
    cmd_t c;
    c.action        = act;
    c.range_start   = s;
    c.range_length  = len;
    c.handle        = h;
    c.query_address = q;
    c.drain         = drain;
    pend_q.push_back(c);
    if (act == ACT_ADD && gen_start.size() < CAP) begin
      gen_start.push_back(s);
      gen_len.push_back(len);
      gen_handle.push_back(h);
    end
  endtask

  // random add: clustered starts give overlaps, top-of-space starts run past the top
  task automatic rand_add();
    logic [AW-1:0] s;
    logic [LW-1:0] len;
    logic [HW-1:0] h;
    int k;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      s = AW'(48'h1000_0000) + AW'($urandom_range(0, 16'hffff));
    else if (roll < 55) s = ADDR_MAX - AW'($urandom_range(0, 16'hffff));
    else                s = rand_addr();
    roll = $urandom_range(0, 99);
    if (roll < 10)      len = '0;
    else if (roll < 50) len = LW'($urandom_range(1, 16'h1000));
    else                len = LW'($urandom());
    h = (($urandom_range(0, 9) == 0) ? '0 : HW'($urandom()));
    // sometimes a duplicate of an earlier entry, so remove must pick the first
    if (gen_start.size() != 0 && $urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, gen_start.size() - 1);
      s = gen_start[k];
      h = gen_handle[k];
    end
    send_cmd(ACT_ADD, s, len, h, rand_addr());
  endtask

  task automatic rand_remove();
    logic [AW-1:0] s;
    logic [HW-1:0] h;
    int k;
    s = rand_addr();
    h = HW'($urandom());
    if (gen_start.size() != 0 && $urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, gen_start.size() - 1);
      s = gen_start[k];
      // mostly the right handle, at times zero or a wrong one
      case ($urandom_range(0, 5))
        0:       h = '0;
        1:       h = gen_handle[k] ^ HW'(1 << $urandom_range(0, HW - 1));
        default: h = gen_handle[k];
      endcase
    end
    send_cmd(ACT_REMOVE, s, LW'($urandom()), h, rand_addr());
  endtask

  task automatic rand_find();
    logic [AW-1:0] q;
    logic [LW-1:0] len;
    int k;
    q = rand_addr();
    if (gen_start.size() != 0 && $urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, gen_start.size() - 1);
      len = gen_len[k];
      case ($urandom_range(0, 4))
        0:       q = gen_start[k];
        1:       q = gen_start[k] + AW'(len) - AW'(1);   // last byte inside
        2:       q = gen_start[k] + AW'(len);            // first byte past the end
        3:       q = gen_start[k] - AW'(1);              // just below the start
        default: q = gen_start[k] + AW'($urandom_range(0, (len == 0) ? 0 : len - 1));
      endcase
    end
    send_cmd(ACT_FIND, rand_addr(), LW'($urandom()), HW'($urandom()), q);
  endtask

  task automatic rand_mix(int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      rand_add();
      else if (roll < 50) rand_remove();
      else if (roll < 95) rand_find();
      else send_cmd(ACT_NONE, rand_addr(), LW'($urandom()), HW'($urandom()), rand_addr());
      // now and then the sender holds off until the block is fully drained
      if ($urandom_range(0, 49) == 0) pend_q[$].drain = 1;
    end
  endtask

  // wait until every queued command has transferred and every answer is in
  task automatic wait_drained();
    while (pend_q.size() != 0 || start || owed_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // phase one: sender idles about one cycle in five
    send_idle_pct = 20;

    // empty table: nothing can match, unused code answers zeros
    send_cmd(ACT_FIND,   rand_addr(), '0, '0, '0);
    send_cmd(ACT_REMOVE, '0, '0, '0, '0);
    send_cmd(ACT_NONE,   '0, '0, '0, '0);
    // a plain range, a zero-length one, and two whose end passes the top
    send_cmd(ACT_ADD, '0, LW'(32'h100), 32'haaaa_5555, '0);
    send_cmd(ACT_ADD, AW'(48'h5000), '0, 32'h1234_5678, '0);
    send_cmd(ACT_ADD, ADDR_MAX, {LW{1'b1}}, {HW{1'b1}}, '0);
    send_cmd(ACT_ADD, AW'(48'hffff_ffff_0000), {LW{1'b1}}, '0, '0);
    // range edges, zero length never matches, first entry wins on overlap
    send_cmd(ACT_FIND, ADDR_MAX, {LW{1'b1}}, {HW{1'b1}}, '0);
    send_cmd(ACT_FIND, '0, '0, '0, AW'(48'hff));
    send_cmd(ACT_FIND, '0, '0, '0, AW'(48'h100));
    send_cmd(ACT_FIND, '0, '0, '0, AW'(48'h5000));
    send_cmd(ACT_FIND, '0, '0, '0, ADDR_MAX);
    send_cmd(ACT_FIND, '0, '0, '0, AW'(48'hffff_ffff_0000));
    // remove, then find still matches the entry with handle zero
    send_cmd(ACT_REMOVE, '0, '0, 32'haaaa_5555, '0);
    send_cmd(ACT_FIND,   '0, '0, '0, AW'(48'h80));
    // handle-zero remove on an already removed entry, and two misses
    send_cmd(ACT_REMOVE, '0, '0, '0, '0);
    send_cmd(ACT_REMOVE, AW'(48'h10), '0, 32'h1234_5678, '0);
    send_cmd(ACT_REMOVE, ADDR_MAX, '0, '0, '0);
    send_cmd(ACT_NONE, ADDR_MAX, {LW{1'b1}}, {HW{1'b1}}, ADDR_MAX);
    // held back until the block has answered everything before it
    send_cmd(ACT_FIND, '0, '0, '0, '0, 1);

    rand_mix(140);
    wait_drained();

    // phase two: sender mostly idle
    send_idle_pct = 87;
    rand_mix(130);
    wait_drained();

    // phase three: back to back; by now the table is full and adds are dropped
    send_idle_pct = 0;
    rand_mix(130);
    wait_drained();

    // let any stray answer show up before closing
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d answers: %0d adds stored, %0d dropped on a full table",
             n_checked, n_added, n_dropped);
    $display("finds %0d hit / %0d miss, removes %0d hit / %0d miss, %0d unused codes",
             n_find_hit, n_find_miss, n_rm_hit, n_rm_miss, n_none);
    if (n_err == 0) begin
      $display("tb_address_range_symbol_table_top: done, clean");
    end else begin
      $display("tb_address_range_symbol_table_top: done, errors");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_address_range_symbol_table_top: done, errors");
    $finish;
  end

endmodule
